// ===== sv/soft_core_coulomb_pair_force_core_defines.svh =====
// Assertion macros shared by the soft-core Coulomb pair force RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SOFT_CORE_COULOMB_PAIR_FORCE_CORE_DEFINES_SVH
`define SOFT_CORE_COULOMB_PAIR_FORCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCCPF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCCPF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sccpf_pkg.sv =====
// Shared types, constants and helpers for the soft-core Coulomb pair force block.
// No dependencies.
package sccpf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int REG_W         = 31;
    localparam int CHARGE_W      = 32;
    localparam int FAC_W         = 17;
    localparam int OUT_W         = 32;
    localparam int VAL_W         = 63;
    localparam int CFG_IDX_W     = 4;
    localparam logic [VAL_W-1:0] CAP = VAL_W'(1) << (VAL_W - 1);

    localparam int MUL_LAT = 3;
    localparam int DIV_LAT = VAL_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_SOFTENING   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COULOMB_CONSTANT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_SCALE_SAME_0  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_SCALE_MIXED   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_SCALE_SAME_1  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ_SAME_0   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ_MIXED    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ_SAME_1   = 4'd7;

    localparam logic [1:0] REGION_NONE  = 2'd0;
    localparam logic [1:0] REGION_SOFT  = 2'd1;
    localparam logic [1:0] REGION_PLAIN = 2'd2;

    typedef struct packed {
        logic                       type_first;
        logic                       type_second;
        logic signed [CHARGE_W-1:0] charge_first;
        logic signed [CHARGE_W-1:0] charge_second;
        logic [REG_W-1:0]           distance_sq;
        logic [FAC_W-1:0]           special_factor;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] force_over_dist;
        logic signed [OUT_W-1:0] pair_energy;
        logic [1:0]              region;
    } out_item_t;

    // per-pair data that rides alongside the arithmetic
    typedef struct packed {
        logic                neg;
        logic [REG_W-1:0]    rsq;
        logic [REG_W-1:0]    cut;
        logic [REG_W-1:0]    scale;
        logic [CHARGE_W-1:0] m0;
        logic [CHARGE_W-1:0] m1;
        logic [FAC_W-1:0]    fac;
    } side_t;

    typedef struct packed {
        logic             neg;
        logic             beyond;
        logic             inner;
        logic [REG_W-1:0] rsq;
        logic [VAL_W-1:0] pre;
        logic [VAL_W-1:0] r;
        logic [VAL_W-1:0] ci2;
        logic [VAL_W-1:0] ci;
    } stu_t;

    typedef struct packed {
        logic             neg;
        logic             beyond;
        logic             inner;
        logic [REG_W-1:0] rsq;
        logic [VAL_W-1:0] pre;
    } stv_t;

    typedef struct packed {
        logic             neg;
        logic             beyond;
        logic             inner;
        logic [VAL_W-1:0] e_plain;
    } stw_t;

    // magnitude plus sign to saturated 32-bit two's complement
    function automatic logic [OUT_W-1:0] sat_out(logic [VAL_W-1:0] m, logic neg);
        logic [OUT_W-1:0] res;
        if (neg) begin
            if (m >= (VAL_W'(1) << (OUT_W - 1))) begin
                res = OUT_W'(1) << (OUT_W - 1);
            end else begin
                res = OUT_W'(0) - m[OUT_W-1:0];
            end
        end else begin
            if (m > VAL_W'({1'b0, {(OUT_W-1){1'b1}}})) begin
                res = {1'b0, {(OUT_W-1){1'b1}}};
            end else begin
                res = m[OUT_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/soft_core_coulomb_pair_force_core.sv =====
// Soft-core Coulomb pair force engine, one atom pair per clock while the output is not stalled.
// Input beat (s_*): two type codes, two Q16.16 charges, squared distance and
// special-bond factor. Output beat (m_*): force/r, pair energy, region code.
// Config writes (cfg_*) load the eight Q16.16 registers; cfg_ready is always
// high, indexes above the list are dropped. Write only while the pipe is empty.
// Throughput: one beat per cycle while the output is not stalled. The path from
// input accept to m_valid runs through the square-root pipe, one multiplier
// and two 65-stage divider rounds.
// The whole pipe shares one enable: it moves when the output register is
// empty or being taken. A stalled receiver freezes every stage, bubbles
// included, so nothing is dropped or repeated; s_ready follows that enable.
// Reset (aresetn low, synchronous) clears all valid bits and the config
// registers; payload registers are left as they are.
// Depends on sccpf_pkg and the defines header; uses sccpf_mulq, sccpf_divq,
// sccpf_isqrt and sccpf_delay.
`include "soft_core_coulomb_pair_force_core_defines.svh"

module soft_core_coulomb_pair_force_core #(
    parameter int FRAC_BITS = sccpf_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sccpf_pkg::in_item_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sccpf_pkg::out_item_t            m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sccpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sccpf_pkg::REG_W-1:0]     cfg_data
);
    localparam int VW      = sccpf_pkg::VAL_W;
    localparam int RW      = sccpf_pkg::REG_W;
    localparam int ML      = sccpf_pkg::MUL_LAT;
    localparam int DL      = sccpf_pkg::DIV_LAT;
    localparam int SQ_LAT  = (RW + FRAC_BITS + 1) / 2 + 1;
    // the multiplier front end starts late so ci2 lands with the root
    localparam int DS      = SQ_LAT - 4 * ML;
    localparam int TOTAL   = SQ_LAT + ML + 2 * DL;

    // config registers
    logic [RW-1:0] sigma_reg, kc_reg;
    logic [RW-1:0] scale0_reg, scalem_reg, scale1_reg;
    logic [RW-1:0] cut0_reg, cutm_reg, cut1_reg;

    logic                 en;
    logic [TOTAL:0]       vld_reg;
    sccpf_pkg::in_item_t  item_reg;
    logic                 out_valid_reg;
    sccpf_pkg::out_item_t out_data_reg, out_data_next;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || m_ready;
    assign s_ready   = en;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg  <= '0;
            kc_reg     <= '0;
            scale0_reg <= '0;
            scalem_reg <= '0;
            scale1_reg <= '0;
            cut0_reg   <= '0;
            cutm_reg   <= '0;
            cut1_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sccpf_pkg::CFG_CHARGE_SOFTENING:  sigma_reg  <= cfg_data;
                sccpf_pkg::CFG_COULOMB_CONSTANT:  kc_reg     <= cfg_data;
                sccpf_pkg::CFG_SOFT_SCALE_SAME_0: scale0_reg <= cfg_data;
                sccpf_pkg::CFG_SOFT_SCALE_MIXED:  scalem_reg <= cfg_data;
                sccpf_pkg::CFG_SOFT_SCALE_SAME_1: scale1_reg <= cfg_data;
                sccpf_pkg::CFG_CUTOFF_SQ_SAME_0:  cut0_reg   <= cfg_data;
                sccpf_pkg::CFG_CUTOFF_SQ_MIXED:   cutm_reg   <= cfg_data;
                sccpf_pkg::CFG_CUTOFF_SQ_SAME_1:  cut1_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits walk alongside the data; index 0 is the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= s_data;
        end
    end

    // stage t0: charge magnitudes, pair table lookup
    sccpf_pkg::side_t side0, side_a, side_b, side_c;
    logic n0, n1;

    always_comb begin
        n0         = item_reg.charge_first[31];
        n1         = item_reg.charge_second[31];
        side0.neg  = n0 != n1;
        side0.rsq  = item_reg.distance_sq;
        side0.fac  = item_reg.special_factor;
        side0.m0   = n0 ? 32'(0) - item_reg.charge_first : item_reg.charge_first;
        side0.m1   = n1 ? 32'(0) - item_reg.charge_second : item_reg.charge_second;
        if (item_reg.type_first != item_reg.type_second) begin
            side0.scale = scalem_reg;
            side0.cut   = cutm_reg;
        end else if (!item_reg.type_first) begin
            side0.scale = scale0_reg;
            side0.cut   = cut0_reg;
        end else begin
            side0.scale = scale1_reg;
            side0.cut   = cut1_reg;
        end
    end

    logic [VW-1:0] r_s;
    sccpf_isqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .aclk(aclk), .en(en), .rsq(item_reg.distance_sq), .root(r_s)
    );

    sccpf_delay #(.W($bits(sccpf_pkg::side_t)), .DEPTH(DS)) u_dly_a (
        .aclk(aclk), .en(en), .d(side0), .q(side_a)
    );
    sccpf_delay #(.W($bits(sccpf_pkg::side_t)), .DEPTH(2 * ML)) u_dly_b (
        .aclk(aclk), .en(en), .d(side_a), .q(side_b)
    );
    sccpf_delay #(.W($bits(sccpf_pkg::side_t)), .DEPTH(2 * ML)) u_dly_c (
        .aclk(aclk), .en(en), .d(side_b), .q(side_c)
    );

    // multiplier front end: aq, kf -> pre, sigma*aq -> ci -> ci2
    logic [VW-1:0] aq, kf, pre, sg, onep, ci, ci2, ci_s, pre_s;
    logic [VW:0]   onep_sum;

    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_aq (
        .aclk(aclk), .en(en), .a(VW'(side_a.m0)), .b(VW'(side_a.m1)), .p(aq)
    );
    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_kf (
        .aclk(aclk), .en(en), .a(VW'(kc_reg)), .b(VW'(side_a.fac)), .p(kf)
    );
    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_pre (
        .aclk(aclk), .en(en), .a(kf), .b(aq), .p(pre)
    );
    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_sg (
        .aclk(aclk), .en(en), .a(VW'(sigma_reg)), .b(aq), .p(sg)
    );

    always_comb begin
        onep_sum = {1'b0, sg} + ((VW + 1)'(1) << FRAC_BITS);
        onep     = (onep_sum > (VW + 1)'(sccpf_pkg::CAP)) ? sccpf_pkg::CAP : onep_sum[VW-1:0];
    end

    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_ci (
        .aclk(aclk), .en(en), .a(onep), .b(VW'(side_b.scale)), .p(ci)
    );
    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_ci2 (
        .aclk(aclk), .en(en), .a(ci), .b(ci), .p(ci2)
    );
    sccpf_delay #(.W(VW), .DEPTH(ML)) u_dly_ci (
        .aclk(aclk), .en(en), .d(ci), .q(ci_s)
    );
    sccpf_delay #(.W(VW), .DEPTH(2 * ML)) u_dly_pre (
        .aclk(aclk), .en(en), .d(pre), .q(pre_s)
    );

    // stage tS: region decision, ci3 and ci2*r
    sccpf_pkg::stu_t su, su_u;
    logic [VW-1:0]   ci3, ci2r;

    always_comb begin
        su.neg    = side_c.neg;
        su.beyond = side_c.rsq > side_c.cut;
        su.inner  = VW'(side_c.rsq) <= ci2;
        su.rsq    = side_c.rsq;
        su.pre    = pre_s;
        su.r      = r_s;
        su.ci2    = ci2;
        su.ci     = ci_s;
    end

    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_ci3 (
        .aclk(aclk), .en(en), .a(ci2), .b(ci_s), .p(ci3)
    );
    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_ci2r (
        .aclk(aclk), .en(en), .a(ci2), .b(r_s), .p(ci2r)
    );
    sccpf_delay #(.W($bits(sccpf_pkg::stu_t)), .DEPTH(ML)) u_dly_u (
        .aclk(aclk), .en(en), .d(su), .q(su_u)
    );

    // first divider round: five quotients; slot 0 is shared with the plain path
    logic [VW-1:0] d0_a, d0_b, three_f, two_f, three_r;
    logic [VW-1:0] q0, qa2, qa3, qb1, qb2;

    always_comb begin
        three_f = VW'(3) << FRAC_BITS;
        two_f   = VW'(2) << FRAC_BITS;
        three_r = (su_u.r << 1) + su_u.r;
        d0_a    = su_u.inner ? VW'(su_u.rsq) : su_u.pre;
        d0_b    = su_u.inner ? ci3 : su_u.r;
    end

    sccpf_divq #(.FRAC_BITS(FRAC_BITS)) u_div0 (
        .aclk(aclk), .en(en), .a(d0_a), .b(d0_b), .q(q0)
    );
    sccpf_divq #(.FRAC_BITS(FRAC_BITS)) u_div_a2 (
        .aclk(aclk), .en(en), .a(three_r), .b(su_u.ci2), .q(qa2)
    );
    sccpf_divq #(.FRAC_BITS(FRAC_BITS)) u_div_a3 (
        .aclk(aclk), .en(en), .a(three_f), .b(su_u.ci), .q(qa3)
    );
    sccpf_divq #(.FRAC_BITS(FRAC_BITS)) u_div_b1 (
        .aclk(aclk), .en(en), .a(three_f), .b(ci2r), .q(qb1)
    );
    sccpf_divq #(.FRAC_BITS(FRAC_BITS)) u_div_b2 (
        .aclk(aclk), .en(en), .a(two_f), .b(ci3), .q(qb2)
    );

    sccpf_pkg::stv_t sv_in, sv_v;
    always_comb begin
        sv_in.neg    = su_u.neg;
        sv_in.beyond = su_u.beyond;
        sv_in.inner  = su_u.inner;
        sv_in.rsq    = su_u.rsq;
        sv_in.pre    = su_u.pre;
    end
    sccpf_delay #(.W($bits(sccpf_pkg::stv_t)), .DEPTH(DL)) u_dly_v (
        .aclk(aclk), .en(en), .d(sv_in), .q(sv_v)
    );

    // stage tV: brackets (clamped at zero), second round
    logic [VW:0]   a13;
    logic [VW-1:0] poly, fp, f_plain, e_soft, f_soft, e_soft_w, f_soft_w;

    always_comb begin
        a13  = {1'b0, q0} + {1'b0, qa3};
        poly = (a13 >= {1'b0, qa2}) ? VW'(a13 - {1'b0, qa2}) : '0;
        fp   = (qb1 >= qb2) ? qb1 - qb2 : '0;
    end

    sccpf_divq #(.FRAC_BITS(FRAC_BITS)) u_div_f (
        .aclk(aclk), .en(en), .a(q0), .b(VW'(sv_v.rsq)), .q(f_plain)
    );
    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_e (
        .aclk(aclk), .en(en), .a(sv_v.pre), .b(poly), .p(e_soft)
    );
    sccpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_f (
        .aclk(aclk), .en(en), .a(sv_v.pre), .b(fp), .p(f_soft)
    );
    sccpf_delay #(.W(VW), .DEPTH(DL - ML)) u_dly_es (
        .aclk(aclk), .en(en), .d(e_soft), .q(e_soft_w)
    );
    sccpf_delay #(.W(VW), .DEPTH(DL - ML)) u_dly_fs (
        .aclk(aclk), .en(en), .d(f_soft), .q(f_soft_w)
    );

    sccpf_pkg::stw_t sw_in, sw_w;
    always_comb begin
        sw_in.neg     = sv_v.neg;
        sw_in.beyond  = sv_v.beyond;
        sw_in.inner   = sv_v.inner;
        sw_in.e_plain = q0;
    end
    sccpf_delay #(.W($bits(sccpf_pkg::stw_t)), .DEPTH(DL)) u_dly_w (
        .aclk(aclk), .en(en), .d(sw_in), .q(sw_w)
    );

    // stage tW: pick region, saturate, into the output register
    always_comb begin
        if (sw_w.beyond) begin
            out_data_next.force_over_dist = '0;
            out_data_next.pair_energy     = '0;
            out_data_next.region          = sccpf_pkg::REGION_NONE;
        end else if (sw_w.inner) begin
            out_data_next.force_over_dist = sccpf_pkg::sat_out(f_soft_w, sw_w.neg);
            out_data_next.pair_energy     = sccpf_pkg::sat_out(e_soft_w, sw_w.neg);
            out_data_next.region          = sccpf_pkg::REGION_SOFT;
        end else begin
            out_data_next.force_over_dist = sccpf_pkg::sat_out(f_plain, sw_w.neg);
            out_data_next.pair_energy     = sccpf_pkg::sat_out(sw_w.e_plain, sw_w.neg);
            out_data_next.region          = sccpf_pkg::REGION_PLAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_reg[TOTAL];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    `SCCPF_ASSERT_IMP(a_cutoff_zero, aclk, aresetn,
        m_valid && m_data.region == sccpf_pkg::REGION_NONE,
        m_data.force_over_dist == '0 && m_data.pair_energy == '0,
        "beyond-cutoff beat carries nonzero force or energy")
    `SCCPF_ASSERT_IMP(a_plain_sign, aclk, aresetn,
        m_valid && m_data.region == sccpf_pkg::REGION_PLAIN && m_data.force_over_dist != '0,
        m_data.force_over_dist[31] == m_data.pair_energy[31],
        "plain Coulomb force and energy disagree in sign")
    `SCCPF_ASSERT_NXT(a_stall_hold, aclk, aresetn,
        m_valid && !m_ready,
        $stable(vld_reg),
        "pipeline valid bits moved during an output stall")
endmodule

// ===== sv/sccpf_mulq.sv =====
// Three-stage fixed-point multiplier with rounding and cap at 2^62.
// Depends on sccpf_pkg.
module sccpf_mulq #(
    parameter int FRAC_BITS = sccpf_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [sccpf_pkg::VAL_W-1:0] a,
    input  logic [sccpf_pkg::VAL_W-1:0] b,
    output logic [sccpf_pkg::VAL_W-1:0] p
);
    localparam int VW    = sccpf_pkg::VAL_W;
    localparam int SUM_W = 2 * VW + 1;

    logic [63:0]      pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [SUM_W-1:0] sum_reg, sum_next, sh;
    logic [VW-1:0]    p_reg, p_next;

    // partial products of the 32-bit low and 31-bit high halves
    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg <= 64'(a[31:0] * b[31:0]);
            pp_lh_reg <= 64'(a[31:0] * b[VW-1:32]);
            pp_hl_reg <= 64'(a[VW-1:32] * b[31:0]);
            pp_hh_reg <= 64'(a[VW-1:32] * b[VW-1:32]);
        end
    end

    always_comb begin
        sum_next = SUM_W'(pp_ll_reg)
                 + (SUM_W'(pp_lh_reg) << 32)
                 + (SUM_W'(pp_hl_reg) << 32)
                 + (SUM_W'(pp_hh_reg) << 64)
                 + (SUM_W'(1) << (FRAC_BITS - 1));
        sh     = sum_reg >> FRAC_BITS;
        p_next = (sh > SUM_W'(sccpf_pkg::CAP)) ? sccpf_pkg::CAP : sh[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;
endmodule

// ===== sv/sccpf_divq.sv =====
// Pipelined restoring divider: round-half-up of a*2^F/b, capped at 2^62.
// One quotient bit per stage. Depends on sccpf_pkg.
module sccpf_divq #(
    parameter int FRAC_BITS = sccpf_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [sccpf_pkg::VAL_W-1:0] a,
    input  logic [sccpf_pkg::VAL_W-1:0] b,
    output logic [sccpf_pkg::VAL_W-1:0] q
);
    localparam int VW    = sccpf_pkg::VAL_W;
    localparam int NUM_W = VW + FRAC_BITS + 1;
    localparam int REM_W = VW + 1;

    logic [REM_W-1:0] rem_reg [0:VW];
    logic [VW-1:0]    low_reg [0:VW];
    logic [VW-1:0]    den_reg [0:VW];
    logic [VW-1:0]    quo_reg [0:VW];
    logic [2:0]       flg_reg [0:VW];   // {div by zero, numerator nonzero, overflow}
    logic [VW-1:0]    q_reg, q_next;
    logic [NUM_W-1:0] num;
    logic             ovf;

    always_comb begin
        num = (NUM_W'(a) << FRAC_BITS) + NUM_W'(b >> 1);
        ovf = VW'(num[NUM_W-1:VW]) >= b;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= REM_W'(num[NUM_W-1:VW]);
            low_reg[0] <= num[VW-1:0];
            den_reg[0] <= b;
            quo_reg[0] <= '0;
            flg_reg[0] <= {b == '0, a != '0, ovf};
        end
    end

    for (genvar k = 0; k < VW; k++) begin : g_step
        logic [REM_W-1:0] trial;
        logic             ge;
        always_comb begin
            trial = {rem_reg[k][REM_W-2:0], low_reg[k][VW-1-k]};
            ge    = trial >= {1'b0, den_reg[k]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? trial - {1'b0, den_reg[k]} : trial;
                low_reg[k+1] <= low_reg[k];
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= {quo_reg[k][VW-2:0], ge};
                flg_reg[k+1] <= flg_reg[k];
            end
        end
    end

    always_comb begin
        if (flg_reg[VW][2]) begin
            q_next = flg_reg[VW][1] ? sccpf_pkg::CAP : '0;
        end else if (flg_reg[VW][0] || quo_reg[VW] > sccpf_pkg::CAP) begin
            q_next = sccpf_pkg::CAP;
        end else begin
            q_next = quo_reg[VW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule

// ===== sv/sccpf_isqrt.sv =====
// Pipelined integer square root of rsq*2^F, one root bit per stage.
// Depends on sccpf_pkg.
module sccpf_isqrt #(
    parameter int FRAC_BITS = sccpf_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [sccpf_pkg::REG_W-1:0] rsq,
    output logic [sccpf_pkg::VAL_W-1:0] root
);
    localparam int ROOT_W = (sccpf_pkg::REG_W + FRAC_BITS + 1) / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int RAD_W  = 2 * ROOT_W;

    logic [REM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            rad_reg[0]  <= RAD_W'({rsq, {FRAC_BITS{1'b0}}});
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0] rem_sh, trial;
        logic             ge;
        always_comb begin
            rem_sh = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_W-1-2*k -: 2]};
            trial  = {root_reg[k], 2'b01};
            ge     = rem_sh >= trial;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], ge};
                rad_reg[k+1]  <= rad_reg[k];
            end
        end
    end

    assign root = sccpf_pkg::VAL_W'(root_reg[ROOT_W]);
endmodule

// ===== sv/sccpf_delay.sv =====
// Enable-gated shift line used to carry side data past the arithmetic units.
// No dependencies.
module sccpf_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] pipe_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];
endmodule

// ===== test/tb_soft_core_coulomb_pair_force_core.sv =====
// Self-checking testbench for soft_core_coulomb_pair_force_core.
// Random and directed pair beats go through the block and are checked against a
// fixed-point predictor of the pair force. Depends on sccpf_pkg and the block RTL.
module tb_soft_core_coulomb_pair_force_core;
    import sccpf_pkg::*;

    localparam int FRAC = 16;
    localparam logic [63:0] CAP64 = 64'd1 << 62;
    localparam int DRAIN = 200;  // well past the pipeline latency

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;

    soft_core_coulomb_pair_force_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor's own copy of the eight registers
    logic [REG_W-1:0] reg_copy [8];
    in_item_t pair_q[$];        // beats waiting to be offered
    out_item_t force_q[$];      // predicted results, oldest first
    int errors = 0;
    int beats_in = 0;
    int cycle_cnt = 0;
    logic in_taken = 1'b0;
    logic hold_off = 1'b0;

    // --- fixed-point helpers, magnitudes only ---
    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b} + (128'd1 << (FRAC - 1))) >> FRAC;
        return (p > {64'd0, CAP64}) ? CAP64 : p[63:0];
    endfunction

    function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
        logic [127:0] q;
        if (b == 0) return (a != 0) ? CAP64 : 64'd0;
        q = (({64'd0, a} << FRAC) + {65'd0, b[63:1]}) / {64'd0, b};
        return (q > {64'd0, CAP64}) ? CAP64 : q[63:0];
    endfunction

    function automatic logic [63:0] fx_sqrt(logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] signed_sat(logic [63:0] m, logic neg);
        if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'h1_0000_0000 - m);
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic out_item_t pair_force(in_item_t it);
        out_item_t o;
        logic neg;
        logic [63:0] m0, m1, rsq, scale, cut, aq, pre, onep, ci, ci2, ci3, r, e, f;
        logic [63:0] a1, a2, a3, b1, b2;
        o = '0;
        if (it.type_first != it.type_second) begin
            scale = 64'(reg_copy[CFG_SOFT_SCALE_MIXED]);
            cut = 64'(reg_copy[CFG_CUTOFF_SQ_MIXED]);
        end else if (!it.type_first) begin
            scale = 64'(reg_copy[CFG_SOFT_SCALE_SAME_0]);
            cut = 64'(reg_copy[CFG_CUTOFF_SQ_SAME_0]);
        end else begin
            scale = 64'(reg_copy[CFG_SOFT_SCALE_SAME_1]);
            cut = 64'(reg_copy[CFG_CUTOFF_SQ_SAME_1]);
        end
        rsq = 64'(it.distance_sq);
        if (rsq > cut) begin
            o.region = REGION_NONE;
            return o;
        end
        neg = it.charge_first[31] ^ it.charge_second[31];
        m0 = it.charge_first[31] ? 64'h1_0000_0000 - 64'(it.charge_first[31:0])
                                 : 64'(it.charge_first[31:0]);
        m1 = it.charge_second[31] ? 64'h1_0000_0000 - 64'(it.charge_second[31:0])
                                  : 64'(it.charge_second[31:0]);
        aq = fx_mul(m0, m1);
        pre = fx_mul(fx_mul(64'(reg_copy[CFG_COULOMB_CONSTANT]), 64'(it.special_factor)), aq);
        onep = (64'd1 << FRAC) + fx_mul(64'(reg_copy[CFG_CHARGE_SOFTENING]), aq);
        if (onep > CAP64) onep = CAP64;
        ci = fx_mul(onep, scale);
        ci2 = fx_mul(ci, ci);
        r = fx_sqrt(rsq << FRAC);
        if (rsq > ci2) begin
            e = fx_div(pre, r);
            f = fx_div(e, rsq);
            o.region = REGION_PLAIN;
        end else begin
            ci3 = fx_mul(ci2, ci);
            a1 = fx_div(rsq, ci3);
            a2 = fx_div(64'd3 * r, ci2);
            a3 = fx_div(64'd3 << FRAC, ci);
            b1 = fx_div(64'd3 << FRAC, fx_mul(ci2, r));
            b2 = fx_div(64'd2 << FRAC, ci3);
            e = fx_mul(pre, (a1 + a3 >= a2) ? a1 + a3 - a2 : 64'd0);
            f = fx_mul(pre, (b1 >= b2) ? b1 - b2 : 64'd0);
            o.region = REGION_SOFT;
        end
        o.force_over_dist = signed_sat(f, neg);
        o.pair_energy = signed_sat(e, neg);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
        errors++;
    endtask

    // --- monitor: sample every handshake at the rising edge ---
    always @(posedge aclk) begin
        out_item_t want;
        cycle_cnt <= cycle_cnt + 1;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready && cfg_index <= CFG_CUTOFF_SQ_SAME_1)
                reg_copy[cfg_index[2:0]] = cfg_data;
            if (in_taken) begin
                force_q.push_back(pair_force(s_data));
                beats_in++;
            end
            if (m_valid && m_ready) begin
                if (force_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_data.force_over_dist, 32'd0);
                end else begin
                    want = force_q.pop_front();
                    if (m_data.force_over_dist !== want.force_over_dist)
                        report_mismatch("force_over_dist", m_data.force_over_dist,
                                        want.force_over_dist);
                    if (m_data.pair_energy !== want.pair_energy)
                        report_mismatch("pair_energy", m_data.pair_energy, want.pair_energy);
                    if (m_data.region !== want.region)
                        report_mismatch("region", 32'(m_data.region), 32'(want.region));
                end
            end
        end
    end

    // no idling in a long calm window
    function automatic logic idle_now();
        if (cycle_cnt >= 1500 && cycle_cnt < 2500) return 1'b0;
        return $urandom_range(0, 99) < 38;
    endfunction

    // --- driver: next beat at the falling edge once the last one is taken ---
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pair_q.size() != 0 && !idle_now()) begin
                s_data <= pair_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus the long hold-off below
    always @(negedge aclk) begin
        m_ready <= aresetn && !hold_off && !idle_now();
    end

    // long receiver hold-off while the sender keeps offering, fills the pipe
    initial begin
        wait (beats_in >= 300);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (700) @(negedge aclk);
        hold_off = 1'b0;
    end

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic load_regs(logic [REG_W-1:0] v [8]);
        for (int i = 0; i < 8; i++) reg_write(CFG_IDX_W'(i), v[i]);
        reg_write(4'd9, 31'($urandom));  // beyond the list, must be dropped
        cfg_valid <= 1'b0;
    endtask

    // wait until every beat is out and checked, then let the pipe settle
    task automatic drain();
        wait (pair_q.size() == 0 && !s_valid && force_q.size() == 0);
        repeat (DRAIN) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_charge();
        logic [31:0] c;
        case ($urandom_range(0, 7))
            0: c = $urandom;
            1: c = 32'h8000_0000;
            2: c = 32'h7FFF_FFFF;
            3: c = 32'd0;
            default: begin
                c = $urandom_range(0, 8 << 16);
                if ($urandom_range(0, 1)) c = -c;
            end
        endcase
        return c;
    endfunction

    function automatic in_item_t random_pair();
        in_item_t it;
        logic [REG_W-1:0] cut;
        it.type_first = 1'($urandom_range(0, 1));
        it.type_second = 1'($urandom_range(0, 1));
        it.charge_first = pick_charge();
        it.charge_second = pick_charge();
        if (it.type_first != it.type_second) cut = reg_copy[CFG_CUTOFF_SQ_MIXED];
        else if (!it.type_first) cut = reg_copy[CFG_CUTOFF_SQ_SAME_0];
        else cut = reg_copy[CFG_CUTOFF_SQ_SAME_1];
        case ($urandom_range(0, 9))
            0, 1: it.distance_sq = 31'($urandom);
            2, 3: it.distance_sq = 31'($urandom_range(0, 6 << 16));
            4: it.distance_sq = cut + 31'($urandom_range(0, 1));
            default: it.distance_sq = 31'($urandom_range(0, cut));
        endcase
        it.special_factor = ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                                        : 17'($urandom_range(0, 65536));
        return it;
    endfunction

    function automatic in_item_t make_pair(logic t0, logic t1, logic [31:0] q0,
                                           logic [31:0] q1, logic [30:0] rsq,
                                           logic [16:0] fac);
        in_item_t it;
        it.type_first = t0;
        it.type_second = t1;
        it.charge_first = q0;
        it.charge_second = q1;
        it.distance_sq = rsq;
        it.special_factor = fac;
        return it;
    endfunction

    initial begin
        logic [REG_W-1:0] setting [8];
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 8; i++) reg_copy[i] = '0;

        // registers at reset: zero cutoff, so only zero distance lands inside
        pair_q.push_back(make_pair(1'b0, 1'b0, 32'h0001_0000, 32'h0001_0000, 31'd0, 17'h10000));
        pair_q.push_back(make_pair(1'b1, 1'b0, 32'h0001_0000, 32'h0001_0000, 31'd1, 17'h10000));
        drain();

        // typical physics-like setting
        setting = '{31'd32768, 31'd21762000, 31'd65536, 31'd98304, 31'd131072,
                    31'd6553600, 31'd4194304, 31'd9437184};
        load_regs(setting);
        pair_q.push_back(make_pair(1'b0, 1'b0, 32'h0001_0000, 32'h0001_0000, 31'd0, 17'h10000));
        pair_q.push_back(make_pair(1'b0, 1'b0, 32'hFFFF_0000, 32'h0001_0000, 31'd0, 17'h10000));
        pair_q.push_back(make_pair(1'b0, 1'b0, 32'h0, 32'h0001_0000, 31'd0, 17'h10000));
        pair_q.push_back(make_pair(1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 31'd65536,
                                   17'h10000));
        pair_q.push_back(make_pair(1'b0, 1'b0, 32'h8000_0000, 32'h8000_0000, 31'd100,
                                   17'h1FFFF));
        pair_q.push_back(make_pair(1'b0, 1'b0, 32'h0001_0000, 32'hFFFF_0000, 31'd6553600,
                                   17'h8000));
        pair_q.push_back(make_pair(1'b0, 1'b0, 32'h0001_0000, 32'hFFFF_0000, 31'd6553601,
                                   17'h8000));
        pair_q.push_back(make_pair(1'b0, 1'b1, 32'h0002_0000, 32'h0001_0000, 31'd4194304,
                                   17'h0));
        pair_q.push_back(make_pair(1'b1, 1'b0, 32'h0002_0000, 32'hFFFE_0000, 31'd65536,
                                   17'h10000));
        pair_q.push_back(make_pair(1'b1, 1'b1, 32'h0000_8000, 32'h0003_0000, 31'd9437184,
                                   17'h10000));
        pair_q.push_back(make_pair(1'b1, 1'b1, 32'h0000_8000, 32'h0003_0000, 31'h7FFF_FFFF,
                                   17'h10000));
        pair_q.push_back(make_pair(1'b1, 1'b1, 32'h0001_0000, 32'h0001_0000, 31'd300000,
                                   17'h10000));
        pair_q.push_back(make_pair(1'b0, 1'b1, 32'h0001_0000, 32'h0001_0000, 31'd200000,
                                   17'h1FFFF));
        for (int i = 0; i < 600; i++) pair_q.push_back(random_pair());
        drain();

        // every register at its top, then zero scale with wide cutoffs
        for (int i = 0; i < 8; i++) setting[i] = 31'h7FFF_FFFF;
        load_regs(setting);
        pair_q.push_back(make_pair(1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                   17'h1FFFF));
        pair_q.push_back(make_pair(1'b1, 1'b1, 32'h8000_0000, 32'h0000_0001, 31'd0, 17'h10000));
        for (int i = 0; i < 250; i++) pair_q.push_back(random_pair());
        drain();

        setting = '{31'd0, 31'd65536, 31'd0, 31'd0, 31'd0,
                    31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
        load_regs(setting);
        pair_q.push_back(make_pair(1'b0, 1'b1, 32'h0001_0000, 32'h0001_0000, 31'd0, 17'h10000));
        for (int i = 0; i < 250; i++) pair_q.push_back(random_pair());
        drain();

        // a few random settings
        for (int p = 0; p < 3; p++) begin
            setting[0] = 31'($urandom_range(0, 2 << 16));
            setting[1] = 31'($urandom);
            for (int i = 2; i < 5; i++) setting[i] = 31'($urandom_range(0, 4 << 16));
            for (int i = 5; i < 8; i++) setting[i] = 31'($urandom_range(0, 200 << 16));
            load_regs(setting);
            for (int i = 0; i < 220; i++) pair_q.push_back(random_pair());
            drain();
        end

        if (errors == 0 && force_q.size() == 0) begin
            $display("soft_core_coulomb_pair_force_core test passed");
        end else begin
            $display("soft_core_coulomb_pair_force_core test failed");
        end
        $finish;
    end

    initial begin
        #(8 * 1_000_000);
        $display("soft_core_coulomb_pair_force_core test failed");
        $finish;
    end

endmodule

// ===== soft_core_coulomb_pair_force_core.f =====
+incdir+sv
sv/sccpf_pkg.sv
sv/sccpf_mulq.sv
sv/sccpf_divq.sv
sv/sccpf_isqrt.sv
sv/sccpf_delay.sv
sv/soft_core_coulomb_pair_force_core.sv
test/tb_soft_core_coulomb_pair_force_core.sv
